FILE: src/ste_pkg.sv
// Package for the semaphore table engine: sizes, opcodes, status codes and
// the beat types shared by the front end, back end and queue. No dependencies.
package ste_pkg;

  localparam int NUM_SEMS    = 16;
  localparam int QUEUE_DEPTH = 8;
  localparam int COUNT_BITS  = 16;

  localparam int SID_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int WADDR_W = SID_W + QPTR_W;
  localparam int WDEPTH  = NUM_SEMS * QUEUE_DEPTH;
  localparam int CQ_DEPTH = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_POST    = 3'd2,
    OP_WAIT    = 3'd3,
    OP_OPEN    = 3'd4
  } opcode_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_IN_USE    = 3'd2;
  localparam logic [2:0] ST_BLOCKED   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_SATURATED = 3'd5;

  // Classified command passed from front end to back end.
  typedef struct packed {
    logic [2:0]            opcode;
    logic                  id_ok;
    logic [SID_W-1:0]      sid;
    logic                  init_sat;
    logic [COUNT_BITS-1:0] init_count;
    logic [7:0]            proc_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        woken_valid;
    logic [7:0]  woken_proc;
    logic [15:0] count_after;
  } rsp_t;

endpackage

FILE: src/ste_if.sv
// Valid/ready channel interfaces for the semaphore table engine.
// Depends on nothing.
interface ste_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [7:0]  sem_id;
  logic [15:0] init_value;
  logic [7:0]  proc_id;
  modport source (output valid, opcode, sem_id, init_value, proc_id, input ready);
  modport sink   (input valid, opcode, sem_id, init_value, proc_id, output ready);
endinterface

interface ste_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        woken_valid;
  logic [7:0]  woken_proc;
  logic [15:0] count_after;
  modport source (output valid, status, woken_valid, woken_proc, count_after,
                  input ready);
  modport sink   (input valid, status, woken_valid, woken_proc, count_after,
                  output ready);
endinterface

FILE: src/ste_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ste_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: src/ste_front.sv
// Front end: accepts request beats, checks the id and clamps the initial
// count, producing a classified command. Depends on ste_pkg and ste_if.
module ste_front (
  ste_req_if.sink       req,
  output logic          cmd_valid,
  output ste_pkg::cmd_t cmd,
  input  logic          cmd_ready
);
  import ste_pkg::*;

  logic [15:0] init_max;

  assign init_max  = 16'(COUNT_MAX);
  assign req.ready = cmd_ready;

  // Classification is combinational; the queue behind registers it.
  always_comb begin
    cmd_valid      = req.valid;
    cmd.opcode     = req.opcode;
    cmd.id_ok      = {24'd0, req.sem_id} < 32'(NUM_SEMS);
    cmd.sid        = SID_W'(req.sem_id);
    cmd.init_sat   = (COUNT_BITS < 16) && (req.init_value > init_max);
    cmd.init_count = cmd.init_sat ? COUNT_MAX : COUNT_BITS'(req.init_value);
    cmd.proc_id    = req.proc_id;
  end
endmodule

FILE: src/ste_cmd_queue.sv
// Two-entry command queue between front end and back end.
// Depends on ste_pkg.
module ste_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  ste_pkg::cmd_t in_cmd,
  output logic          in_ready,
  output logic          out_valid,
  output ste_pkg::cmd_t out_cmd,
  input  logic          out_ready
);
  import ste_pkg::*;

  cmd_t       slots [CQ_DEPTH];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready  = fill != 2'(CQ_DEPTH);
  assign out_valid = fill != 2'd0;
  assign out_cmd   = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Payload slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: src/ste_back.sv
// Back end: executes each command as a memory read, then an update and result,
// driving the response register. Depends on ste_pkg, ste_ram, ste_if.
module ste_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  ste_pkg::cmd_t cmd,
  output logic          cmd_ready,
  ste_rsp_if.source     rsp
);
  import ste_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t              state;
  cmd_t                cur;
  logic [NUM_SEMS-1:0] in_use;
  logic [QPTR_W-1:0]   head [NUM_SEMS];
  logic [QFILL_W-1:0]  fill [NUM_SEMS];
  rsp_t                out_reg;
  logic                out_valid;

  logic                  take;
  logic                  cnt_we;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic                  wq_we;
  logic [WADDR_W-1:0]    wq_waddr;
  logic [WADDR_W-1:0]    wq_raddr;
  logic [7:0]            wq_rdata;
  logic [QPTR_W-1:0]     cur_head;
  logic [QFILL_W-1:0]    cur_fill;
  logic [QPTR_W-1:0]     tail;
  logic                  open_ok;
  rsp_t                  res;
  logic                  set_use;
  logic                  clr_use;
  logic                  head_inc;
  logic                  fill_inc;
  logic                  fill_dec;

  // A new command is taken when idle and the result register is free or is
  // being drained in the same cycle.
  assign take      = (state == S_IDLE) && cmd_valid && (!out_valid || rsp.ready);
  assign cmd_ready = take;

  assign cur_head = head[cur.sid];
  assign cur_fill = fill[cur.sid];
  assign tail     = QPTR_W'((32'(cur_head) + 32'(cur_fill)) % QUEUE_DEPTH);
  assign wq_raddr = {cmd.sid, head[cmd.sid]};
  assign wq_waddr = {cur.sid, tail};
  assign open_ok  = cur.id_ok && in_use[cur.sid];

  ste_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_SEMS)) u_count (
    .clk(clk), .wr_en(cnt_we), .wr_addr(cur.sid), .wr_data(cnt_wdata),
    .rd_addr(cmd.sid), .rd_data(cnt_rdata)
  );

  ste_ram #(.WIDTH(8), .DEPTH(WDEPTH)) u_waitq (
    .clk(clk), .wr_en(wq_we), .wr_addr(wq_waddr), .wr_data(cur.proc_id),
    .rd_addr(wq_raddr), .rd_data(wq_rdata)
  );

  // Operation decode on the read-back entry.
  always_comb begin
    res       = '0;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_rdata;
    wq_we     = 1'b0;
    set_use   = 1'b0;
    clr_use   = 1'b0;
    head_inc  = 1'b0;
    fill_inc  = 1'b0;
    fill_dec  = 1'b0;
    res.status = ST_INVALID;
    if (cur.opcode == OP_CREATE) begin
      if (!cur.id_ok) begin
        res.status = ST_INVALID;
      end else if (in_use[cur.sid]) begin
        res.status      = ST_IN_USE;
        res.count_after = 16'(cnt_rdata);
      end else begin
        res.status      = cur.init_sat ? ST_SATURATED : ST_OK;
        res.count_after = 16'(cur.init_count);
        cnt_we          = 1'b1;
        cnt_wdata       = cur.init_count;
        set_use         = 1'b1;
      end
    end else if (open_ok) begin
      case (cur.opcode)
        OP_DESTROY: begin
          res.status = ST_OK;
          clr_use    = 1'b1;
        end
        OP_POST: begin
          res.count_after = 16'(cnt_rdata);
          if (cur_fill != '0) begin
            res.status      = ST_OK;
            res.woken_valid = 1'b1;
            res.woken_proc  = wq_rdata;
            head_inc        = 1'b1;
            fill_dec        = 1'b1;
          end else if (cnt_rdata == COUNT_MAX) begin
            res.status = ST_SATURATED;
          end else begin
            res.status      = ST_OK;
            cnt_we          = 1'b1;
            cnt_wdata       = cnt_rdata + 1'b1;
            res.count_after = 16'(cnt_wdata);
          end
        end
        OP_WAIT: begin
          res.count_after = 16'(cnt_rdata);
          if (cnt_rdata != '0) begin
            res.status      = ST_OK;
            cnt_we          = 1'b1;
            cnt_wdata       = cnt_rdata - 1'b1;
            res.count_after = 16'(cnt_wdata);
          end else if (32'(cur_fill) >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            res.status = ST_BLOCKED;
            wq_we      = 1'b1;
            fill_inc   = 1'b1;
          end
        end
        OP_OPEN: begin
          res.status      = ST_OK;
          res.count_after = 16'(cnt_rdata);
        end
        default: begin
          res.status = ST_INVALID;
        end
      endcase
    end
    if (state != S_EXEC) begin
      cnt_we = 1'b0;
      wq_we  = 1'b0;
    end
  end

  // Sequencer, table state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_use    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_SEMS; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) state <= S_EXEC;
        end
        S_EXEC: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
          if (set_use || clr_use) begin
            in_use[cur.sid] <= set_use;
            head[cur.sid]   <= '0;
            fill[cur.sid]   <= '0;
          end
          if (head_inc) head[cur.sid] <= QPTR_W'((32'(cur_head) + 1) % QUEUE_DEPTH);
          if (fill_inc) fill[cur.sid] <= cur_fill + 1'b1;
          if (fill_dec) fill[cur.sid] <= cur_fill - 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) cur <= cmd;
    if (state == S_EXEC) out_reg <= res;
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_reg.status;
  assign rsp.woken_valid = out_reg.woken_valid;
  assign rsp.woken_proc  = out_reg.woken_proc;
  assign rsp.count_after = out_reg.count_after;
endmodule

FILE: src/semaphore_table_engine.sv
// Top level of the semaphore table engine: front end, command queue and
// back end. Depends on ste_pkg, ste_if, ste_front, ste_cmd_queue, ste_back.
//
// Usage: requests arrive on the req channel (opcode, sem_id, init_value,
// proc_id) as valid/ready beats; each produces exactly one response beat on
// rsp (status, woken_valid, woken_proc, count_after), in request order.
// The front end classifies a beat and pushes it into a two-entry command
// queue, so requests are taken while the back end is busy.
// The back end first reads the count memory and the head entry of the waiter
// memory, then updates and registers the result, and takes no new command
// while one is executing. A new command starts once the result register is
// free or is being drained in the same cycle.
// Reset clears all in-use flags and queue pointers; the count and waiter
// memories need no clearing since they are written before being read.
// When the receiver stalls, the response holds, the back end stops, and the
// queue fills before req.ready drops.
module semaphore_table_engine (
  input logic     clk,
  input logic     rst,
  ste_req_if.sink   req,
  ste_rsp_if.source rsp
);
  import ste_pkg::*;

  logic f_valid;
  cmd_t f_cmd;
  logic f_ready;
  logic b_valid;
  cmd_t b_cmd;
  logic b_ready;

  ste_front u_front (
    .req(req),
    .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
  );

  ste_cmd_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_cmd(f_cmd), .in_ready(f_ready),
    .out_valid(b_valid), .out_cmd(b_cmd), .out_ready(b_ready)
  );

  ste_back u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(b_valid), .cmd(b_cmd), .cmd_ready(b_ready), .rsp(rsp)
  );

  // A woken process is only reported with an ok status.
  a_woken_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.woken_valid |-> rsp.status == ST_OK)
    else $error("woken process with non-ok status");

  // An invalid status always reports a zero count.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_INVALID |-> rsp.count_after == 16'd0)
    else $error("invalid status with nonzero count");

  // A stalled result stays valid; the back end takes no command while it waits.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid)
    else $error("result lost under stall");
endmodule

FILE: sim/semaphore_table_engine_tb.sv
// Self-checking testbench for the semaphore table engine: directed table then
// random operations, each response checked against an in-bench semaphore model.
// Depends on ste_pkg, ste_if and semaphore_table_engine.
`timescale 1ns / 100ps

module semaphore_table_engine_tb;
  import ste_pkg::*;

  logic clk;
  logic rst;
  ste_req_if req ();
  ste_rsp_if rsp ();

  semaphore_table_engine i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  typedef struct {
    logic [2:0]  opcode;
    logic [7:0]  sem_id;
    logic [15:0] init_value;
    logic [7:0]  proc_id;
  } op_beat_t;

  // Expected response fields.
  typedef struct {
    logic [2:0]  status;
    logic        woken_valid;
    logic [7:0]  woken_proc;
    logic [15:0] count_after;
  } sem_resp_t;

  // Semaphore table copy kept by the bench.
  logic              mdl_in_use [NUM_SEMS];
  logic [15:0]       mdl_count  [NUM_SEMS];
  logic [7:0]        mdl_waiters[NUM_SEMS][QUEUE_DEPTH];
  int unsigned       mdl_head   [NUM_SEMS];
  int unsigned       mdl_fill   [NUM_SEMS];

  sem_resp_t pending_resp[$];
  op_beat_t  op_list[$];
  int        error_count;
  bit        stim_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("semaphore_table_engine_tb: FAIL");
    $finish;
  end

  function automatic sem_resp_t mk_resp(logic [2:0] st, logic wv, logic [7:0] wp,
                                        logic [15:0] cnt);
    sem_resp_t r;
    r.status = st;
    r.woken_valid = wv;
    r.woken_proc = wp;
    r.count_after = cnt;
    return r;
  endfunction

  // Apply one operation to the bench's table and return its response.
  function automatic sem_resp_t apply_sem_op(op_beat_t b);
    int unsigned s;
    int unsigned h;
    int unsigned t;
    logic [7:0]  who;
    s = b.sem_id;
    if (b.opcode == OP_CREATE) begin
      if (b.sem_id >= NUM_SEMS) return mk_resp(ST_INVALID, 0, 0, 0);
      if (mdl_in_use[s]) return mk_resp(ST_IN_USE, 0, 0, mdl_count[s]);
      mdl_in_use[s] = 1'b1;
      mdl_count[s] = b.init_value;
      mdl_head[s] = 0;
      mdl_fill[s] = 0;
      return mk_resp(ST_OK, 0, 0, b.init_value);
    end
    if (b.opcode > OP_OPEN || b.sem_id >= NUM_SEMS || !mdl_in_use[s])
      return mk_resp(ST_INVALID, 0, 0, 0);
    case (b.opcode)
      OP_DESTROY: begin
        mdl_in_use[s] = 1'b0;
        mdl_head[s] = 0;
        mdl_fill[s] = 0;
        return mk_resp(ST_OK, 0, 0, 0);
      end
      OP_POST: begin
        if (mdl_fill[s] > 0) begin
          h = mdl_head[s];
          who = mdl_waiters[s][h];
          mdl_head[s] = (h + 1) % QUEUE_DEPTH;
          mdl_fill[s]--;
          return mk_resp(ST_OK, 1, who, mdl_count[s]);
        end
        if (mdl_count[s] == COUNT_MAX) return mk_resp(ST_SATURATED, 0, 0, mdl_count[s]);
        mdl_count[s]++;
        return mk_resp(ST_OK, 0, 0, mdl_count[s]);
      end
      OP_WAIT: begin
        if (mdl_count[s] > 0) begin
          mdl_count[s]--;
          return mk_resp(ST_OK, 0, 0, mdl_count[s]);
        end
        if (mdl_fill[s] >= QUEUE_DEPTH) return mk_resp(ST_FULL, 0, 0, mdl_count[s]);
        t = (mdl_head[s] + mdl_fill[s]) % QUEUE_DEPTH;
        mdl_waiters[s][t] = b.proc_id;
        mdl_fill[s]++;
        return mk_resp(ST_BLOCKED, 0, 0, mdl_count[s]);
      end
      default: return mk_resp(ST_OK, 0, 0, mdl_count[s]);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic op_beat_t mk_op(logic [2:0] op, logic [7:0] id, logic [15:0] iv,
                                     logic [7:0] pid);
    op_beat_t b;
    b.opcode = op;
    b.sem_id = id;
    b.init_value = iv;
    b.proc_id = pid;
    return b;
  endfunction

  // Random operation: mostly valid ids on a few semaphores, some noise.
  function automatic op_beat_t rand_op();
    op_beat_t b;
    int r;
    r = $urandom_range(0, 99);
    b.proc_id = 8'($urandom);
    b.sem_id = 8'((r < 90) ? $urandom_range(0, 3) + (($urandom_range(0, 9) == 0) ? 12 : 0)
                           : $urandom);
    r = $urandom_range(0, 99);
    if (r < 10) b.opcode = OP_CREATE;
    else if (r < 16) b.opcode = OP_DESTROY;
    else if (r < 48) b.opcode = OP_POST;
    else if (r < 86) b.opcode = OP_WAIT;
    else if (r < 95) b.opcode = OP_OPEN;
    else b.opcode = 3'($urandom_range(5, 7));
    r = $urandom_range(0, 9);
    b.init_value = 16'((r < 6) ? $urandom_range(0, 3)
                               : (r < 8) ? 16'hFFFF - $urandom_range(0, 2) : $urandom);
    return b;
  endfunction

  // Directed table: expected values typed in where obvious, others predicted.
  op_beat_t  dir_op[$];
  sem_resp_t dir_resp[$];
  bit        dir_known[$];

  task automatic add_row(op_beat_t b, bit known, sem_resp_t r);
    dir_op.push_back(b);
    dir_known.push_back(known);
    dir_resp.push_back(r);
  endtask

  // Response side: random stalls, compare every beat.
  always @(posedge clk) begin
    sem_resp_t exp_r;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_resp.size() == 0) begin
          report_mismatch("unexpected beat", rsp.status, 0);
        end else begin
          exp_r = pending_resp.pop_front();
          if (rsp.status !== exp_r.status)
            report_mismatch("status", rsp.status, exp_r.status);
          if (rsp.woken_valid !== exp_r.woken_valid)
            report_mismatch("woken_valid", rsp.woken_valid, exp_r.woken_valid);
          if (rsp.woken_proc !== exp_r.woken_proc)
            report_mismatch("woken_proc", rsp.woken_proc, exp_r.woken_proc);
          if (rsp.count_after !== exp_r.count_after)
            report_mismatch("count_after", rsp.count_after, exp_r.count_after);
        end
      end
      rsp.ready <= (stim_done || $urandom_range(0, 3) != 0) ? 1'b1
                 : ($urandom_range(0, 9) == 0 ? 1'b0 : rsp.ready);
    end
  end

  initial begin
    op_beat_t  b;
    sem_resp_t r;
    sem_resp_t pr;
    int        gap;
    int        wait_cycles;
    error_count = 0;
    stim_done = 0;
    for (int i = 0; i < NUM_SEMS; i++) begin
      mdl_in_use[i] = 0;
      mdl_count[i] = 0;
      mdl_head[i] = 0;
      mdl_fill[i] = 0;
      for (int j = 0; j < QUEUE_DEPTH; j++) mdl_waiters[i][j] = 0;
    end
    rst = 1'b1;
    req.valid = 1'b0;
    req.opcode = OP_OPEN;
    req.sem_id = 0;
    req.init_value = 0;
    req.proc_id = 0;

    r = mk_resp(0, 0, 0, 0);
    // Not open after reset, invalid ids, unknown opcode.
    add_row(mk_op(OP_OPEN, 0, 0, 0), 1, mk_resp(ST_INVALID, 0, 0, 0));
    add_row(mk_op(OP_POST, 5, 0, 0), 1, mk_resp(ST_INVALID, 0, 0, 0));
    add_row(mk_op(OP_CREATE, 8'hFF, 16'hFFFF, 8'hFF), 1, mk_resp(ST_INVALID, 0, 0, 0));
    add_row(mk_op(OP_CREATE, 8'(NUM_SEMS), 1, 0), 1, mk_resp(ST_INVALID, 0, 0, 0));
    add_row(mk_op(3'd7, 0, 16'hFFFF, 8'hFF), 1, mk_resp(ST_INVALID, 0, 0, 0));
    // Saturation at the top of the count.
    add_row(mk_op(OP_CREATE, 15, 16'hFFFF, 0), 1, mk_resp(ST_OK, 0, 0, 16'hFFFF));
    add_row(mk_op(OP_POST, 15, 0, 0), 1, mk_resp(ST_SATURATED, 0, 0, 16'hFFFF));
    add_row(mk_op(OP_CREATE, 15, 0, 0), 1, mk_resp(ST_IN_USE, 0, 0, 16'hFFFF));
    add_row(mk_op(OP_DESTROY, 15, 0, 0), 1, mk_resp(ST_OK, 0, 0, 0));
    // Zero count: fill the wait queue, overflow it, then wake the first waiters by posts.
    add_row(mk_op(OP_CREATE, 0, 0, 0), 1, mk_resp(ST_OK, 0, 0, 0));
    for (int i = 0; i < QUEUE_DEPTH; i++)
      add_row(mk_op(OP_WAIT, 0, 0, 8'((i == 0) ? 8'hFF : 8'h10 + i)), 1,
              mk_resp(ST_BLOCKED, 0, 0, 0));
    add_row(mk_op(OP_WAIT, 0, 0, 8'h55), 1, mk_resp(ST_FULL, 0, 0, 0));
    add_row(mk_op(OP_POST, 0, 0, 0), 1, mk_resp(ST_OK, 1, 8'hFF, 0));
    add_row(mk_op(OP_POST, 0, 0, 0), 0, r);
    add_row(mk_op(OP_WAIT, 0, 0, 8'hAA), 0, r);
    add_row(mk_op(OP_DESTROY, 0, 0, 0), 1, mk_resp(ST_OK, 0, 0, 0));
    add_row(mk_op(OP_CREATE, 0, 2, 0), 1, mk_resp(ST_OK, 0, 0, 2));
    add_row(mk_op(OP_WAIT, 0, 0, 0), 0, r);
    add_row(mk_op(OP_OPEN, 0, 0, 0), 0, r);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // The gap before each beat is drawn at the end of the previous one, so
    // valid is dropped when an idle gap follows or after the last beat.
    gap = gap_len();
    for (int n = 0; n < dir_op.size() + 900; n++) begin
      b = (n < dir_op.size()) ? dir_op[n] : rand_op();
      repeat (gap) @(posedge clk);
      pr = apply_sem_op(b);
      if (n < dir_op.size() && dir_known[n]) begin
        r = dir_resp[n];
        if (r != pr) begin
          report_mismatch("table row", 16'(n), 0);
        end
        pending_resp.push_back(r);
      end else begin
        pending_resp.push_back(pr);
      end
      req.valid <= 1'b1;
      req.opcode <= b.opcode;
      req.sem_id <= b.sem_id;
      req.init_value <= b.init_value;
      req.proc_id <= b.proc_id;
      @(posedge clk);
      while (!req.ready) @(posedge clk);
      gap = gap_len();
      if (gap != 0 || n == dir_op.size() + 899) req.valid <= 1'b0;
    end
    stim_done = 1;

    wait_cycles = 0;
    while (pending_resp.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_resp.size() == 0) begin
      $display("semaphore_table_engine_tb: PASS");
    end else begin
      $display("semaphore_table_engine_tb: FAIL");
    end
    $finish;
  end

endmodule
